/* hdl/rbc_pkg.sv */
package rbc_pkg;

	// Capacity of the value store, 2 to 64
	localparam int MAX_ITEMS = 64;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int VALUE_W = 32;
	localparam int RANK_W = 6;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic is_last;
	} in_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic last_rank;
		logic dropped;
	} out_t;

	// Result offered by the sequencer to the output register
	typedef struct packed {
		logic valid;
		out_t item;
	} res_req_t;

endpackage

/* hdl/rank_by_count_smaller.sv */
// Ranks a list of signed 32-bit values by counting, for each one, the stored values strictly
// smaller than it; equal values share a rank. Values enter one per transfer on the item channel
// until one marked is_last closes the list; up to MAX_ITEMS (64) are kept, later ones are dropped
// and the first result of the list then carries dropped = 1. After the closing transfer the
// block stalls its input and returns one result per stored value, in arrival order, with
// last_rank on the final one. Results are worked out one at a time, bounded by the
// single read port of the value store, which is swept once per result; the next list is
// accepted once the last result has entered the output register. The output register lets the
// block work on the next result while the current one waits to be taken.
module rank_by_count_smaller (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input rbc_pkg::in_t item_data,
	output logic rank_valid,
	input logic rank_stall,
	output rbc_pkg::out_t rank_data
);

	rbc_pkg::res_req_t req;
	logic slot_free;
	logic wr_en;
	logic [rbc_pkg::IDX_W-1:0] wr_addr;
	logic [rbc_pkg::VALUE_W-1:0] wr_data;
	logic [rbc_pkg::IDX_W-1:0] rd_addr;
	logic [rbc_pkg::VALUE_W-1:0] rd_data;
	logic rank_valid_q;
	rbc_pkg::out_t rank_data_q;

	rbc_seq u_seq (
		.clk (clk),
		.arst_n (arst_n),
		.item_valid (item_valid),
		.item (item_data),
		.item_stall (item_stall),
		.slot_free (slot_free),
		.req (req),
		.wr_en (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rbc_ram #(
		.WIDTH (rbc_pkg::VALUE_W),
		.DEPTH (rbc_pkg::MAX_ITEMS)
	) u_store (
		.clk (clk),
		.wr_en (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: load when empty or when its result transfers
	assign slot_free = !rank_valid_q || !rank_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_valid_q <= 1'b0;
		end else if (slot_free) begin
			rank_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && req.valid) begin
			rank_data_q <= req.item;
		end
	end

	assign rank_valid = rank_valid_q;
	assign rank_data = rank_data_q;

`ifndef ASSERT_OFF
	// No list element is taken while a rank is being offered
	a_no_fill_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |-> !req.valid)
		else $error("item accepted while a result is pending");

	// A result refused by the output register is held by the sequencer
	a_req_held: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && !slot_free) |=> (req.valid && $stable(req.item)))
		else $error("pending result changed before transfer");

	// Nothing is written to the store while ranking
	a_no_write_while_ranking: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !item_stall)
		else $error("store written outside the fill phase");
`endif

endmodule

/* hdl/rbc_ram.sv */
module rbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/rbc_seq.sv */
module rbc_seq (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input rbc_pkg::in_t item,
	output logic item_stall,
	input logic slot_free,
	output rbc_pkg::res_req_t req,
	output logic wr_en,
	output logic [rbc_pkg::IDX_W-1:0] wr_addr,
	output logic [rbc_pkg::VALUE_W-1:0] wr_data,
	output logic [rbc_pkg::IDX_W-1:0] rd_addr,
	input logic [rbc_pkg::VALUE_W-1:0] rd_data
);

	typedef enum logic [2:0] {FILL, RD_KEY, GET_KEY, SCAN, EMIT} state_t;

	state_t state_q;
	logic [rbc_pkg::CNT_W-1:0] fill_q;
	logic [rbc_pkg::CNT_W-1:0] n_q;
	logic [rbc_pkg::CNT_W-1:0] i_q;
	logic [rbc_pkg::CNT_W-1:0] j_q;
	logic ovf_q;
	logic signed [rbc_pkg::VALUE_W-1:0] key_q;
	logic [rbc_pkg::RANK_W-1:0] cnt_q;
	logic [rbc_pkg::RANK_W-1:0] rank_q;

	logic accept;
	logic room;
	logic less;
	logic [rbc_pkg::RANK_W-1:0] cnt_nxt;
	logic [rbc_pkg::CNT_W-1:0] i_inc;
	logic last_item;

	// Accept list elements only while filling
	assign item_stall = (state_q != FILL);
	assign accept = item_valid && (state_q == FILL);
	assign room = (fill_q < rbc_pkg::CNT_W'(rbc_pkg::MAX_ITEMS));

	// Store the element at the fill position
	assign wr_en = accept && room;
	assign wr_addr = fill_q[rbc_pkg::IDX_W-1:0];
	assign wr_data = item.value;

	// Select the entry to read: the key, then the sweep over the list
	always_comb begin
		case (state_q)
			RD_KEY: rd_addr = i_q[rbc_pkg::IDX_W-1:0];
			GET_KEY: rd_addr = '0;
			default: rd_addr = j_q[rbc_pkg::IDX_W-1:0];
		endcase
	end

	// Count stored values strictly below the key
	assign less = ($signed(rd_data) < key_q);
	assign cnt_nxt = cnt_q + {{(rbc_pkg::RANK_W-1){1'b0}}, less};

	assign i_inc = i_q + rbc_pkg::CNT_W'(1);
	assign last_item = (i_inc == n_q);

	// Offer the finished rank
	assign req.valid = (state_q == EMIT);
	assign req.item.rank = rank_q;
	assign req.item.last_rank = last_item;
	assign req.item.dropped = (i_q == '0) && ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL;
			fill_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ovf_q <= 1'b0;
			key_q <= '0;
			cnt_q <= '0;
			rank_q <= '0;
		end else begin
			case (state_q)
				FILL: begin
					if (accept) begin
						if (room) begin
							fill_q <= fill_q + rbc_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.is_last) begin
							n_q <= room ? fill_q + rbc_pkg::CNT_W'(1) : fill_q;
							i_q <= '0;
							state_q <= RD_KEY;
						end
					end
				end
				RD_KEY: begin
					state_q <= GET_KEY;
				end
				GET_KEY: begin
					// Latch the key; entry 0 is being read now
					key_q <= $signed(rd_data);
					cnt_q <= '0;
					j_q <= rbc_pkg::CNT_W'(1);
					state_q <= SCAN;
				end
				SCAN: begin
					cnt_q <= cnt_nxt;
					if (j_q == n_q) begin
						rank_q <= cnt_nxt;
						state_q <= EMIT;
					end else begin
						j_q <= j_q + rbc_pkg::CNT_W'(1);
					end
				end
				EMIT: begin
					// Advance once the output register takes the result
					if (slot_free) begin
						if (last_item) begin
							fill_q <= '0;
							ovf_q <= 1'b0;
							state_q <= FILL;
						end else begin
							i_q <= i_inc;
							state_q <= RD_KEY;
						end
					end
				end
				default: begin
					state_q <= FILL;
				end
			endcase
		end
	end

endmodule

/* verif/rank_checker.sv */
module rank_checker
	import rbc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input in_t item_data,
	input logic rank_valid,
	input logic rank_stall,
	input out_t rank_data,
	output int fail_count,
	output int pending
);

	logic signed [VALUE_W-1:0] list_values [MAX_ITEMS];
	int list_len;
	logic list_dropped;
	out_t due_ranks [$];

	// Count, for every kept value of the closed list, the kept values below it
	task automatic rank_closed_list();
		out_t r;
		int smaller;
		for (int i = 0; i < list_len; i++) begin
			smaller = 0;
			for (int j = 0; j < list_len; j++) begin
				if (list_values[j] < list_values[i])
					smaller++;
			end
			r.rank = smaller[RANK_W-1:0];
			r.last_rank = (i == list_len - 1);
			r.dropped = (i == 0) && list_dropped;
			due_ranks.push_back(r);
		end
	endtask

	// Keep the value while there is room, else note the drop; close on is_last
	task automatic take_item(in_t d);
		if (list_len < MAX_ITEMS) begin
			list_values[list_len] = d.value;
			list_len++;
		end else begin
			list_dropped = 1'b1;
		end
		if (d.is_last) begin
			rank_closed_list();
			list_len = 0;
			list_dropped = 1'b0;
		end
	endtask

	// Compare one result transfer with the oldest predicted result
	task automatic compare_rank(out_t got);
		out_t want;
		if (due_ranks.size() == 0) begin
			$error("rank transfer with no result due: rank %0d last_rank %0b dropped %0b",
				got.rank, got.last_rank, got.dropped);
			fail_count++;
		end else begin
			want = due_ranks.pop_front();
			if (got.rank !== want.rank) begin
				$error("rank: expected %0d, got %0d", want.rank, got.rank);
				fail_count++;
			end
			if (got.last_rank !== want.last_rank) begin
				$error("last_rank: expected %0b, got %0b", want.last_rank, got.last_rank);
				fail_count++;
			end
			if (got.dropped !== want.dropped) begin
				$error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
				fail_count++;
			end
		end
	endtask

	// Watch both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			list_dropped = 1'b0;
			due_ranks.delete();
			fail_count = 0;
		end else begin
			if (item_valid && !item_stall)
				take_item(item_data);
			if (rank_valid && !rank_stall)
				compare_rank(rank_data);
		end
		pending = due_ranks.size();
	end

endmodule

/* verif/tb_rank_by_count_smaller.sv */
module tb_rank_by_count_smaller;
	import rbc_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4 * (MAX_ITEMS + 3);
	localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef logic signed [VALUE_W-1:0] word_q_t [$];

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid = 1'b0;
	logic item_stall;
	in_t item_data = '0;
	logic rank_valid;
	logic rank_stall = 1'b0;
	out_t rank_data;
	int fail_count;
	int pending;
	int quiet_cycles = 0;
	idle_mode_t idle_mode = IDLE_NONE;

	rank_by_count_smaller dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.rank_valid(rank_valid),
		.rank_stall(rank_stall),
		.rank_data(rank_data)
	);

	rank_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.rank_valid(rank_valid),
		.rank_stall(rank_stall),
		.rank_data(rank_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 48;
			IDLE_BOTH: return $urandom_range(99) < 12;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 48;
			IDLE_BOTH: return $urandom_range(99) < 12;
			default: return 1'b0;
		endcase
	endfunction

	// Mix full-range values, tight clusters for ties, and the extremes
	function automatic logic signed [VALUE_W-1:0] random_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return $urandom;
		if (pick < 70)
			return int'($urandom_range(8)) - 4;
		if (pick < 85) begin
			case ($urandom_range(4))
				0: return V_MIN;
				1: return V_MAX;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		if (pick < 93)
			return V_MIN + int'($urandom_range(3));
		return V_MAX - int'($urandom_range(3));
	endfunction

	// Mostly short lists; open with one full list and one that overflows by one
	function automatic int random_length(int list_idx);
		int pick;
		if (list_idx == 0)
			return MAX_ITEMS;
		if (list_idx == 1)
			return MAX_ITEMS + 1;
		pick = $urandom_range(99);
		if (pick < 3)
			return MAX_ITEMS + 1 + int'($urandom_range(3));
		if (pick < 6)
			return MAX_ITEMS - int'($urandom_range(1));
		if (pick < 26)
			return $urandom_range(24, 9);
		return $urandom_range(8, 1);
	endfunction

	// Offer one value and hold it until the transfer
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last);
		in_t d;
		d.value = v;
		d.is_last = last;
		while (sender_idles()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= d;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_list(input word_q_t vals);
		for (int i = 0; i < vals.size(); i++)
			send_item(vals[i], i == vals.size() - 1);
	endtask

	// Randomize the result-side stall every cycle
	always @(posedge clk) begin
		rank_stall <= receiver_stalls();
	end

	// Count cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (rank_valid && !rank_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_rank_by_count_smaller NOT OK");
		$finish;
	end

	initial begin
		word_q_t list_vals;
		int list_idx;
		int sent;
		int len;

		// Drive reset low so every reset block sees the falling edge
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-value lists at both ends of the range
		list_vals = '{V_MIN};
		send_list(list_vals);
		list_vals = '{V_MAX};
		send_list(list_vals);
		// Extremes mixed with repeats around zero
		list_vals = '{V_MAX, V_MIN, 0, -1, 1, V_MAX, V_MIN, 0};
		send_list(list_vals);
		// All equal values share one rank
		list_vals = '{5, 5, 5, 5};
		send_list(list_vals);
		// Alternating bit patterns, one of each sign
		list_vals = '{32'sh5555_5555, 32'shAAAA_AAAA};
		send_list(list_vals);
		// Strictly descending
		list_vals = '{3, 2, 1, 0, -1};
		send_list(list_vals);

		// Random lists, stepping through the idle modes every few lists
		list_idx = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_mode <= idle_mode_t'((list_idx / 3) % 4);
			len = random_length(list_idx);
			list_vals.delete();
			for (int i = 0; i < len; i++)
				list_vals.push_back(random_value());
			send_list(list_vals);
			sent += len;
			list_idx++;
		end
		item_valid <= 1'b0;

		// Drain the outstanding results, then give stray ones time to show
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_rank_by_count_smaller OK");
		else
			$display("tb_rank_by_count_smaller NOT OK");
		$finish;
	end

endmodule
